@@ rtl/mmr_pkg.sv @@
package mmr_pkg;

    // Array limits
    localparam int MAX_INNER    = 64;
    localparam int MAX_COLS     = 64;
    localparam int WSTORE_DEPTH = 4096;

    // Field and datapath widths
    localparam int WADDR_W = 12;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int SUM_W   = 32;
    localparam int COL_W   = 6;
    localparam int CNT_W   = 7;
    localparam int ROW_W   = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // Register indexes on the configuration port
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ROWS_M  = 2'd0;
    localparam reg_idx_t REG_INNER_K = 2'd1;
    localparam reg_idx_t REG_COLS_N  = 2'd2;

    // Input item kinds
    localparam logic FUNC_WEIGHT = 1'b0;
    localparam logic FUNC_ELEM   = 1'b1;

    // Effective (clamped) configuration handed to the engine
    typedef struct packed {
        logic [ROW_W-1:0] rows_m;
        logic [CNT_W-1:0] inner_k;
        logic [CNT_W-1:0] cols_n;
    } mmr_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } mmr_state_t;

endpackage

@@ rtl/mmr_ram.sv @@
module mmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mmr_cfg.sv @@
module mmr_cfg
    import mmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output mmr_cfg_t          cfg
);

    logic [ROW_W-1:0] rows_m_reg,  rows_m_next;
    logic [CNT_W-1:0] inner_k_reg, inner_k_next;
    logic [CNT_W-1:0] cols_n_reg,  cols_n_next;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        rows_m_next  = rows_m_reg;
        inner_k_next = inner_k_reg;
        cols_n_next  = cols_n_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ROWS_M:  rows_m_next  = pwdata[ROW_W-1:0];
                REG_INNER_K: inner_k_next = pwdata[CNT_W-1:0];
                REG_COLS_N:  cols_n_next  = pwdata[CNT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= ROW_W'(1);
            inner_k_reg <= CNT_W'(1);
            cols_n_reg  <= CNT_W'(1);
        end
        else
        begin
            rows_m_reg  <= rows_m_next;
            inner_k_reg <= inner_k_next;
            cols_n_reg  <= cols_n_next;
        end
    end

    // Read-back of the stored values
    always_comb
    begin
        unique case (idx)
            REG_ROWS_M:  prdata = APB_DW'(rows_m_reg);
            REG_INNER_K: prdata = APB_DW'(inner_k_reg);
            REG_COLS_N:  prdata = APB_DW'(cols_n_reg);
            default:     prdata = '0;
        endcase
    end

    // Zero acts as one, oversized values clamp to the array limits
    always_comb
    begin
        cfg.rows_m = (rows_m_reg == '0) ? ROW_W'(1) : rows_m_reg;

        if (inner_k_reg == '0)
            cfg.inner_k = CNT_W'(1);
        else if (inner_k_reg > CNT_W'(MAX_INNER))
            cfg.inner_k = CNT_W'(MAX_INNER);
        else
            cfg.inner_k = inner_k_reg;

        if (cols_n_reg == '0)
            cfg.cols_n = CNT_W'(1);
        else if (cols_n_reg > CNT_W'(MAX_COLS))
            cfg.cols_n = CNT_W'(MAX_COLS);
        else
            cfg.cols_n = cols_n_reg;
    end

endmodule

@@ rtl/mmr_engine.sv @@
module mmr_engine
    import mmr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mmr_cfg_t                 cfg,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic [WADDR_W-1:0]       weight_index,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     result_valid,
    output logic [COL_W-1:0]         column,
    output logic signed [SUM_W-1:0]  sum,
    output logic                     last_of_row,
    output logic                     last_of_matrix,
    output logic                     saturated
);

    mmr_state_t state_reg, state_next;

    logic accept, accept_elem;

    // Position counters
    logic [CNT_W-1:0] ep_reg, ep_next;
    logic [ROW_W-1:0] rp_reg, rp_next;
    logic [CNT_W:0]   ep_inc;
    logic [ROW_W:0]   rp_inc;
    logic             row_end, mat_end;

    // Per-element context, held while the columns are swept
    logic signed [VAL_W-1:0] val_reg;
    logic [WADDR_W-1:0]      base_reg;
    logic [CNT_W-1:0]        ncols_reg;
    logic                    row_end_reg, mat_end_reg;
    logic [2*CNT_W-1:0]      base_full;

    // Column sweep
    logic [COL_W-1:0] col_reg, col_next;
    logic             issue, issue_last;

    // Memory ports
    logic [WADDR_W-1:0]      wt_waddr, wt_raddr;
    logic                    wt_we;
    logic signed [VAL_W-1:0] wt_rdata;
    logic                    acc_we;
    logic signed [ACC_W-1:0] acc_wdata, acc_rdata;

    // Pipeline: stage 1 has RAM data, stage 2 the product, stage 3 the result
    logic                     s1_v_reg, s2_v_reg, s3_v_reg;
    logic [COL_W-1:0]         s1_col_reg, s2_col_reg, s3_col_reg;
    logic                     s1_last_reg, s2_last_reg, s3_last_reg;
    logic                     s3_mat_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [ACC_W-1:0]  s2_acc_reg, s3_sum_reg;
    logic signed [ACC_W-1:0]  s2_sum;

    // One valid bit per accumulator; an invalid entry reads as zero
    logic [MAX_COLS-1:0] acc_vld_reg, acc_vld_next;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign accept_elem = accept && (func == FUNC_ELEM);

    // Weight loads go straight into the store at transfer
    assign wt_we    = accept && (func == FUNC_WEIGHT);
    assign wt_waddr = weight_index;

    // Row and matrix position bookkeeping
    assign ep_inc  = {1'b0, ep_reg} + (CNT_W+1)'(1);
    assign row_end = (ep_inc >= {1'b0, cfg.inner_k});
    assign rp_inc  = {1'b0, rp_reg} + (ROW_W+1)'(1);
    assign mat_end = row_end && (rp_inc >= {1'b0, cfg.rows_m});

    always_comb
    begin
        ep_next = ep_reg;
        rp_next = rp_reg;
        if (accept_elem)
        begin
            ep_next = row_end ? '0 : ep_inc[CNT_W-1:0];
            if (row_end)
            begin
                rp_next = mat_end ? '0 : rp_inc[ROW_W-1:0];
            end
        end
    end

    assign base_full = ep_reg * cfg.cols_n;

    always_ff @(posedge clk)
    begin
        if (accept_elem)
        begin
            val_reg     <= value;
            base_reg    <= base_full[WADDR_W-1:0];
            ncols_reg   <= cfg.cols_n;
            row_end_reg <= row_end;
            mat_end_reg <= mat_end;
        end
    end

    // Sequencer: next state
    assign issue      = (state_reg == ST_ISSUE);
    assign issue_last = ({1'b0, col_reg} + CNT_W'(1)) == ncols_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept_elem) state_next = ST_ISSUE;
            ST_ISSUE: if (issue_last)  state_next = ST_DRAIN;
            ST_DRAIN: if (!s1_v_reg)   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: column counter and read addresses
    always_comb
    begin
        col_next = col_reg;
        unique case (state_reg)
            ST_IDLE:  col_next = '0;
            ST_ISSUE: col_next = col_reg + COL_W'(1);
            ST_DRAIN: col_next = '0;
            default:  col_next = '0;
        endcase
    end

    assign wt_raddr = base_reg + WADDR_W'(col_reg);

    // Stage 2: add and write back, or pass to the output on the row's last element
    assign s2_sum    = s2_acc_reg + ACC_W'(s2_prod_reg);
    assign acc_we    = s2_v_reg && !row_end_reg;
    assign acc_wdata = s2_sum;

    always_comb
    begin
        acc_vld_next = acc_vld_reg;
        if (s2_v_reg)
        begin
            if (!row_end_reg)
                acc_vld_next[s2_col_reg] = 1'b1;
            else if (s2_last_reg)
                acc_vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ep_reg      <= '0;
            rp_reg      <= '0;
            col_reg     <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            acc_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ep_reg      <= ep_next;
            rp_reg      <= rp_next;
            col_reg     <= col_next;
            s1_v_reg    <= issue;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg && row_end_reg;
            acc_vld_reg <= acc_vld_next;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_col_reg  <= col_reg;
        s1_last_reg <= issue_last;

        s2_col_reg  <= s1_col_reg;
        s2_last_reg <= s1_last_reg;
        s2_prod_reg <= val_reg * wt_rdata;
        s2_acc_reg  <= acc_vld_reg[s1_col_reg] ? acc_rdata : '0;

        s3_col_reg  <= s2_col_reg;
        s3_last_reg <= s2_last_reg;
        s3_mat_reg  <= mat_end_reg;
        s3_sum_reg  <= s2_sum;
    end

    // Stage 3: saturate to 32 bits and strobe out
    always_comb
    begin
        saturated = 1'b0;
        sum       = s3_sum_reg[SUM_W-1:0];
        if (s3_sum_reg[ACC_W-1:SUM_W-1] != {(ACC_W-SUM_W+1){s3_sum_reg[ACC_W-1]}})
        begin
            saturated = 1'b1;
            sum       = s3_sum_reg[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    assign result_valid   = s3_v_reg;
    assign column         = s3_col_reg;
    assign last_of_row    = s3_last_reg;
    assign last_of_matrix = s3_last_reg && s3_mat_reg;

    mmr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WSTORE_DEPTH)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (value),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    mmr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_COLS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (s2_col_reg),
        .wdata (acc_wdata),
        .raddr (col_reg),
        .rdata (acc_rdata)
    );

endmodule

@@ rtl/matrix_multiply_rows.sv @@
// Row-streaming matrix multiply. Load the right matrix first with func = 0 items (one
// weight per transfer at its flat index, one cycle each, back to back). Then stream the
// left matrix in row-major order with func = 1 items: each element sweeps the output
// columns through the 4096-entry weight store and the 64-entry accumulator memory, one
// multiply-accumulate per cycle, and busy stays high through the issue and drain states; the next
// transfer waits for busy to fall. On the last element of a row the column sums leave on
// result_valid in consecutive cycles, one per column, through the RAM-read, product and
// result stages. The receiver cannot stall: every strobed result must be taken in its
// cycle. Change configuration only while busy is low and no results are pending.
module matrix_multiply_rows
    import mmr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic [WADDR_W-1:0]       weight_index,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     result_valid,
    output logic [COL_W-1:0]         column,
    output logic signed [SUM_W-1:0]  sum,
    output logic                     last_of_row,
    output logic                     last_of_matrix,
    output logic                     saturated
);

    mmr_cfg_t cfg;

    // Configuration registers
    mmr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Weight store, accumulators and MAC sweep
    mmr_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .weight_index   (weight_index),
        .value          (value),
        .result_valid   (result_valid),
        .column         (column),
        .sum            (sum),
        .last_of_row    (last_of_row),
        .last_of_matrix (last_of_matrix),
        .saturated      (saturated)
    );

endmodule
